// ===== rtl/pbr_pkg.sv =====
// shared constants, types and helpers of the packet batching ring
package pbr_pkg;

  localparam int SLOTS       = 3;
  localparam int BUF_BYTES   = 4096;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int OFF_W       = $clog2(BUF_BYTES);
  localparam int FILL_W      = OFF_W + 1;
  localparam int MEM_DEPTH   = SLOTS * BUF_BYTES;
  localparam int MEM_AW      = SLOT_W + OFF_W;
  localparam int CHUNK_W     = 13;
  localparam int PLEN_W      = 13;
  localparam int SUM_W       = ((FILL_W > PLEN_W) ? FILL_W : PLEN_W) + 1;
  localparam int CNT_W       = 12;
  localparam int CFG_DW      = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [31:0]      GAP_RESET   = 32'd1000;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 12'd300;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_READY    = 2'd2
  } status_t;

  typedef enum logic {
    CFG_GAP_LIMIT    = 1'b0,
    CFG_PACKET_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    opcode_t     op;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [12:0] plen;
    logic [31:0] ts;
    logic [11:0] ridx;
  } req_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] write_slot;
    logic [SLOT_W-1:0] read_slot;
  } stat_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/pbr_in_if.sv =====
// request channel of the packet batching ring
interface pbr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  data_byte;
  logic        packet_first;
  logic        packet_last;
  logic [12:0] packet_length;
  logic [31:0] timestamp;
  logic [11:0] read_index;

  modport source(output valid, opcode, data_byte, packet_first, packet_last,
                 packet_length, timestamp, read_index, input ready);
  modport sink(input valid, opcode, data_byte, packet_first, packet_last,
               packet_length, timestamp, read_index, output ready);
endinterface

// ===== rtl/pbr_out_if.sv =====
// result channel of the packet batching ring
interface pbr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [12:0] chunk_length;
  logic [7:0]  read_data;
  logic        overflow;
  logic        dropped;
  logic        host_irq;

  modport source(output valid, status, chunk_length, read_data, overflow, dropped,
                 host_irq, input ready);
  modport sink(input valid, status, chunk_length, read_data, overflow, dropped,
               host_irq, output ready);
endinterface

// ===== rtl/pbr_front.sv =====
// front end: accepts requests, decodes them and queues them for the core
module pbr_front
  import pbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pbr_in_if.sink    in_ch,
  output req_t      req,
  output logic      req_valid,
  input  logic      req_take
);

  req_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  req_t       dec;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = req_take && (cnt_r != 2'd0);
  assign req_valid   = (cnt_r != 2'd0);
  assign req         = q_r[rd_ptr_r];

  always_comb begin
    dec.op        = opcode_t'(in_ch.opcode);
    dec.data_byte = in_ch.data_byte;
    dec.first     = in_ch.packet_first;
    dec.last      = in_ch.packet_last;
    dec.plen      = in_ch.packet_length;
    dec.ts        = in_ch.timestamp;
    dec.ridx      = in_ch.read_index;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== rtl/pbr_core.sv =====
// back end: ring state, slot and window memories, copy engine, result register
module pbr_core
  import pbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  req_t              req,
  input  logic              req_valid,
  output logic              req_take,
  pbr_out_if.source         out_ch,
  output stat_t             stat
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RDW   = 4'b0010,
    S_COPY  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [31:0]       gap_limit_r;
  logic [CNT_W-1:0]  pkt_limit_r;
  logic [FILL_W-1:0] fill_r [SLOTS];
  logic [FILL_W-1:0] fill_nxt [SLOTS];
  logic [CNT_W-1:0]  pkts_r [SLOTS];
  logic [CNT_W-1:0]  pkts_nxt [SLOTS];
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [SLOT_W-1:0] rs_r, rs_nxt;
  logic              clr_r, clr_nxt;
  logic              ovf_r, ovf_nxt;
  logic [31:0]       lt_r, lt_nxt;
  logic              drop_r, drop_nxt;
  logic              irq_r, irq_nxt;

  logic [FILL_W-1:0] cp_cnt_r, cp_cnt_nxt;
  logic [FILL_W-1:0] cp_len_r, cp_len_nxt;
  logic [SLOT_W-1:0] cp_slot_r, cp_slot_nxt;
  logic              cp_wr_r;
  logic [OFF_W-1:0]  cp_waddr_r;

  logic [7:0]        slot_mem [MEM_DEPTH];
  logic [7:0]        win_mem [BUF_BYTES];
  logic [7:0]        slot_rd_r;
  logic [7:0]        win_rd_r;
  logic              rd_oor_r;

  logic              out_valid_r;
  status_t           out_status_r, st_v;
  logic [CHUNK_W-1:0] out_chunk_r, chunk_v;
  logic [7:0]        out_rdata_r;
  logic              out_ovf_r, out_drop_r, out_irq_r;

  logic              out_free;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic              gap_hit;
  logic              done;
  logic [FILL_W-1:0] qn;

  assign out_free = !out_valid_r || out_ch.ready;
  assign req_take = req_valid && (state_r == S_IDLE) && out_free;

  assign stat.busy       = (state_r != S_IDLE);
  assign stat.write_slot = ws_r;
  assign stat.read_slot  = rs_r;

  always_comb begin
    fill_nxt    = fill_r;
    pkts_nxt    = pkts_r;
    ws_nxt      = ws_r;
    rs_nxt      = rs_r;
    clr_nxt     = clr_r;
    ovf_nxt     = ovf_r;
    lt_nxt      = lt_r;
    drop_nxt    = drop_r;
    irq_nxt     = irq_r;
    state_nxt   = state_r;
    cp_cnt_nxt  = cp_cnt_r;
    cp_len_nxt  = cp_len_r;
    cp_slot_nxt = cp_slot_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    st_v        = ST_NONE;
    chunk_v     = '0;
    gap_hit     = 1'b0;
    done        = 1'b0;
    qn          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_take) begin
          unique case (req.op)
            OP_APPEND: begin
              if (req.first) begin
                irq_nxt = 1'b1;
                if (clr_r) begin
                  ws_nxt  = '0;
                  rs_nxt  = '0;
                  clr_nxt = 1'b0;
                  for (int i = 0; i < SLOTS; i++) begin
                    fill_nxt[i] = '0;
                    pkts_nxt[i] = '0;
                  end
                end
                drop_nxt = 1'b0;
                if (SUM_W'(req.plen) + SUM_W'(fill_nxt[ws_nxt]) > SUM_W'(BUF_BYTES)) begin
                  if (next_slot(ws_nxt) == rs_nxt) begin
                    drop_nxt = 1'b1;
                    ovf_nxt  = 1'b1;
                  end else begin
                    ws_nxt           = next_slot(ws_nxt);
                    fill_nxt[ws_nxt] = '0;
                    pkts_nxt[ws_nxt] = '0;
                  end
                end
              end
              if (!drop_nxt) begin
                if (fill_nxt[ws_nxt] < FILL_W'(BUF_BYTES)) begin
                  mem_we           = 1'b1;
                  mem_waddr        = {ws_nxt, fill_nxt[ws_nxt][OFF_W-1:0]};
                  fill_nxt[ws_nxt] = fill_nxt[ws_nxt] + 1'b1;
                end
                if (req.last) begin
                  if (pkts_nxt[ws_nxt] < COUNT_MAX) begin
                    pkts_nxt[ws_nxt] = pkts_nxt[ws_nxt] + 1'b1;
                  end
                  gap_hit = (lt_r != 32'd0) && ((req.ts - lt_r) > gap_limit_r);
                  if (gap_hit) begin
                    if (next_slot(ws_nxt) == rs_nxt) begin
                      ovf_nxt = 1'b1;
                      done    = 1'b1;
                    end else begin
                      ws_nxt           = next_slot(ws_nxt);
                      fill_nxt[ws_nxt] = '0;
                      pkts_nxt[ws_nxt] = '0;
                    end
                  end
                  if (!done) begin
                    lt_nxt = req.ts;
                    if (pkts_nxt[ws_nxt] > pkt_limit_r) begin
                      if (next_slot(ws_nxt) == rs_nxt) begin
                        ovf_nxt = 1'b1;
                        done    = 1'b1;
                      end else begin
                        ws_nxt           = next_slot(ws_nxt);
                        fill_nxt[ws_nxt] = '0;
                        pkts_nxt[ws_nxt] = '0;
                      end
                    end
                  end
                  if (!done) begin
                    ovf_nxt = 1'b0;
                  end
                end
              end
            end
            OP_QUERY: begin
              st_v = ovf_r ? ST_OVERFLOW : ST_NONE;
              if (!clr_r && (rs_r != ws_r)) begin
                qn      = fill_r[rs_r];
                st_v    = ST_READY;
                chunk_v = CHUNK_W'(qn);
                rs_nxt  = next_slot(rs_r);
                if (qn != '0) begin
                  cp_cnt_nxt  = '0;
                  cp_len_nxt  = qn;
                  cp_slot_nxt = rs_r;
                  state_nxt   = S_COPY;
                end
              end else begin
                irq_nxt = 1'b0;
              end
            end
            OP_READ: begin
              state_nxt = S_RDW;
            end
            OP_CLEAR: begin
              ovf_nxt = 1'b0;
              clr_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDW: begin
        state_nxt = S_IDLE;
      end
      S_COPY: begin
        cp_cnt_nxt = cp_cnt_r + 1'b1;
        if (cp_cnt_nxt == cp_len_r) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gap_limit_r <= GAP_RESET;
      pkt_limit_r <= LIMIT_RESET;
      ws_r        <= '0;
      rs_r        <= '0;
      clr_r       <= 1'b1;
      ovf_r       <= 1'b0;
      lt_r        <= '0;
      drop_r      <= 1'b0;
      irq_r       <= 1'b0;
      cp_wr_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        fill_r[i] <= '0;
        pkts_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ws_r    <= ws_nxt;
      rs_r    <= rs_nxt;
      clr_r   <= clr_nxt;
      ovf_r   <= ovf_nxt;
      lt_r    <= lt_nxt;
      drop_r  <= drop_nxt;
      irq_r   <= irq_nxt;
      fill_r  <= fill_nxt;
      pkts_r  <= pkts_nxt;
      cp_wr_r <= (state_r == S_COPY);
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GAP_LIMIT:    gap_limit_r <= cfg_data;
          CFG_PACKET_LIMIT: pkt_limit_r <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      // results load either straight from a request or after the window read
      if ((req_take && (req.op != OP_READ)) || (state_r == S_RDW)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (req_take && (req.op != OP_READ)) begin
      out_status_r <= st_v;
      out_chunk_r  <= chunk_v;
      out_rdata_r  <= 8'd0;
      out_ovf_r    <= ovf_nxt;
      out_drop_r   <= drop_nxt;
      out_irq_r    <= irq_nxt;
    end else if (state_r == S_RDW) begin
      out_status_r <= ST_NONE;
      out_chunk_r  <= '0;
      out_rdata_r  <= rd_oor_r ? 8'd0 : win_rd_r;
      out_ovf_r    <= ovf_r;
      out_drop_r   <= drop_r;
      out_irq_r    <= irq_r;
    end
  end

  // copy pipeline bookkeeping
  always_ff @(posedge clk) begin
    cp_cnt_r   <= cp_cnt_nxt;
    cp_len_r   <= cp_len_nxt;
    cp_slot_r  <= cp_slot_nxt;
    cp_waddr_r <= cp_cnt_r[OFF_W-1:0];
    rd_oor_r   <= (32'(req.ridx) >= 32'(BUF_BYTES));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= req.data_byte;
    end
    slot_rd_r <= slot_mem[{cp_slot_r, cp_cnt_r[OFF_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cp_wr_r) begin
      win_mem[cp_waddr_r] <= slot_rd_r;
    end
    win_rd_r <= win_mem[OFF_W'(req.ridx)];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.chunk_length = out_chunk_r;
  assign out_ch.read_data    = out_rdata_r;
  assign out_ch.overflow     = out_ovf_r;
  assign out_ch.dropped      = out_drop_r;
  assign out_ch.host_irq     = out_irq_r;

endmodule

// ===== rtl/packet_batching_buffer_ring.sv =====
// packet batching ring: ring of byte slots filled by a packet stream, drained by queries
// Requests enter on in_ch (valid/ready) and land in a two-entry queue; the core
// takes one request at a time and returns exactly one result on out_ch.
// Append, clear and an empty query leave the core idle, so a packet streams in
// at one byte per cycle while out_ch takes each result. A read passes through
// S_RDW (registered window memory read). A query that hands out a slot of n
// bytes enters the copy engine, which moves one byte per cycle through the
// single read port of the slot memory into the window memory and ends in S_FLUSH.
// Its result is loaded into the output register when the query is taken.
// cfg_we/cfg_index/cfg_data write gap_limit (index 0) and packet_limit (1).
// Reset (synchronous, rst_n low) empties the ring, sets the pending clear and
// restores the limits to 1000 and 300; slot bytes are undefined until written.
// When out_ch stalls, one result waits in the output register, the core stops
// after it and the request queue fills, then in_ch.ready drops.
module packet_batching_buffer_ring
  import pbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  pbr_in_if.sink            in_ch,
  pbr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  req_t  req;
  logic  req_valid;
  logic  req_take;
  stat_t stat;

  pbr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .req      (req),
    .req_valid(req_valid),
    .req_take (req_take)
  );

  pbr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .req_valid(req_valid),
    .req_take (req_take),
    .out_ch   (out_ch),
    .stat     (stat)
  );

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(stat.write_slot) < SLOTS) && (32'(stat.read_slot) < SLOTS))
    else $error("ring pointer out of range");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !req_take)
    else $error("request taken while core busy");

  a_busy_holds_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.busy && $past(stat.busy)) |-> $stable(stat.write_slot))
    else $error("write slot moved during copy");

endmodule
